// File: rtl/core/isc_pkg.sv
// Shared widths and constants for the iterative sine/cosine generator.
`default_nettype none

package isc_pkg;

    localparam int IDX_W      = 12;
    localparam int VAL_W      = 21;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // accumulators are signed with headroom: cosine may dip below zero
    localparam int ACC_W      = 23;
    localparam int COEF_W     = 11;
    localparam int PROD_W     = ACC_W + COEF_W;
    localparam int UNIT_SHIFT = 20;

    localparam logic [IDX_W-1:0]        MAX_INDEX = IDX_W'(4000);
    localparam logic signed [COEF_W-1:0] STEP_COEF = COEF_W'(412);
    localparam logic signed [ACC_W-1:0]  ONE_UNIT  = ACC_W'(1 << UNIT_SHIFT);

    // clamp a signed accumulator into the unsigned output field
    function automatic logic [VAL_W-1:0] clamp_out(input logic signed [ACC_W-1:0] v);
        logic [VAL_W-1:0] res;
        if (v[ACC_W-1]) begin
            res = '0;
        end else if (|v[ACC_W-2:VAL_W]) begin
            res = '1;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/iterative_sine_cosine.sv
// Top level of the iterative sine/cosine generator (Minsky circle recurrence).
`default_nettype none

// Each request carries an angle index in steps of 2*pi/16000; indexes above
// 4000 (a quarter wave) saturate to 4000. The block starts from cosine 2^20,
// sine 0 and runs one Minsky step per index count: the cosine is lowered by
// floor(sine*412/2^20), then the sine raised by floor(new cosine*412/2^20).
// One result holding both values, clamped to 0..2^21-1, comes back per
// request. A single multiply-accumulate unit serves both halves of a step,
// so each step passes through a cosine state and then a sine state. A
// request is accepted in the idle state, runs its recurrence steps, then
// waits in the done state while the output register still holds an untaken
// result, then hands its result off to the output register. The input is
// ready only while the sequencer is idle; the output register holds a
// finished result until it is taken, and the next request may be accepted
// meanwhile. Nothing is kept between requests.

module iterative_sine_cosine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request: [11:0] angle_index, [15:12] zero
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [isc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // result: [20:0] sine_value, [41:21] cosine_value, [47:42] zero
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [isc_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata
);
    import isc_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RUN_COS = 2'd1;
    localparam logic [1:0] ST_RUN_SIN = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_steps, n_steps;
    logic signed [ACC_W-1:0] r_sin, n_sin;
    logic signed [ACC_W-1:0] r_cos, n_cos;
    logic                    r_out_valid, n_out_valid;
    logic [VAL_W-1:0]        r_out_sin, n_out_sin;
    logic [VAL_W-1:0]        r_out_cos, n_out_cos;

    logic                    in_accept;
    logic                    out_take;
    logic [IDX_W-1:0]        req_index;
    logic [IDX_W-1:0]        sat_index;
    logic signed [ACC_W-1:0] unit_mult;
    logic signed [ACC_W-1:0] unit_acc;
    logic                    unit_sub;
    logic signed [ACC_W-1:0] unit_result;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take        = r_out_valid && i_m_axis_tready;
    assign req_index       = i_s_axis_tdata[IDX_W-1:0];
    assign sat_index       = (req_index > MAX_INDEX) ? MAX_INDEX : req_index;

    // cosine phase multiplies the sine, sine phase multiplies the new cosine
    assign unit_sub  = (r_state == ST_RUN_COS);
    assign unit_mult = unit_sub ? r_sin : r_cos;
    assign unit_acc  = unit_sub ? r_cos : r_sin;

    isc_step_unit u_step (
        .i_mult     (unit_mult),
        .i_acc      (unit_acc),
        .i_subtract (unit_sub),
        .o_result   (unit_result)
    );

    always_comb begin
        n_state     = r_state;
        n_steps     = r_steps;
        n_sin       = r_sin;
        n_cos       = r_cos;
        n_out_valid = r_out_valid && !out_take;
        n_out_sin   = r_out_sin;
        n_out_cos   = r_out_cos;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_cos   = ONE_UNIT;
                    n_sin   = '0;
                    n_steps = sat_index;
                    n_state = (sat_index == '0) ? ST_DONE : ST_RUN_COS;
                end
            end
            ST_RUN_COS: begin
                n_cos   = unit_result;
                n_state = ST_RUN_SIN;
            end
            ST_RUN_SIN: begin
                n_sin   = unit_result;
                n_steps = r_steps - IDX_W'(1);
                n_state = (r_steps == IDX_W'(1)) ? ST_DONE : ST_RUN_COS;
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_sin   = clamp_out(r_sin);
                    n_out_cos   = clamp_out(r_cos);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sin     <= n_sin;
        r_cos     <= n_cos;
        r_out_sin <= n_out_sin;
        r_out_cos <= n_out_cos;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - 2 * VAL_W)'(0), r_out_cos, r_out_sin};

    // a zero index skips the recurrence entirely
    a_zero_index_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (req_index == '0)) |=> (r_state == ST_DONE))
        else $error("zero index did not go straight to done");

    // the recurrence never runs with no steps left
    a_steps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN_COS) || (r_state == ST_RUN_SIN)) |-> (r_steps != '0))
        else $error("recurrence running with zero steps left");

    // every request starts from the unit vector
    a_load_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ((r_cos == ONE_UNIT) && (r_sin == '0)))
        else $error("accumulators not loaded with the unit vector");

    // a result is handed off only from the done state
    a_emit_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result emitted outside the done state");

endmodule

`default_nettype wire

// File: rtl/core/isc_step_unit.sv
// Shared recurrence unit: acc +/- floor(mult * 412 / 2^20).
`default_nettype none

module isc_step_unit (
    input  wire logic signed [isc_pkg::ACC_W-1:0] i_mult,
    input  wire logic signed [isc_pkg::ACC_W-1:0] i_acc,
    input  wire logic                             i_subtract,
    output logic signed [isc_pkg::ACC_W-1:0]      o_result
);
    import isc_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] scaled;
    logic signed [ACC_W-1:0]  delta;

    always_comb begin
        prod   = PROD_W'(i_mult) * PROD_W'(STEP_COEF);
        // arithmetic shift is a floor division for negative products
        scaled = prod >>> UNIT_SHIFT;
        delta  = scaled[ACC_W-1:0];
        if (i_subtract) begin
            o_result = i_acc - delta;
        end else begin
            o_result = i_acc + delta;
        end
    end

endmodule

`default_nettype wire
